@@ hw/rtl/crf_pkg.sv @@
// shared types and codes for the closable ring fifo
// no dependencies; imported by crf_seq, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package crf_pkg;

   // default sizing
   localparam int DEPTH_DEF        = 1024;
   localparam int ELEMENT_BITS_DEF = 64;
   localparam int MAX_BURST_DEF    = 64;

   // fixed field widths of the request and response
   localparam int CMD_W    = 3;
   localparam int DATA_W   = 64;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 11;

   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 80;
   localparam int RSP_TUSER_W = 3;

   // command codes
   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_N = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PULL   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PULL_N = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd4;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_WAIT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CLOSED = 2'd2;

   // response fields apart from the element itself
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                data_valid;
      logic                last;
      logic [FILL_W-1:0]   fill_level;
   } crf_meta_type;

   // sequencer result stage towards the output register
   typedef struct packed {
      logic         valid;
      crf_meta_type meta;
   } crf_stage_type;

endpackage : crf_pkg

`default_nettype wire

@@ hw/rtl/crf_ram.sv @@
// generic single-clock ram, one write and one read port, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module crf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // data holds while no read is issued
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : crf_ram

`default_nettype wire

@@ hw/rtl/crf_seq.sv @@
// command sequencer: pointers, fill count, open flag, burst read issue
// depends on crf_pkg; drives the ports of crf_ram
`timescale 1ns / 1ps
`default_nettype none

module crf_seq #(
   parameter int DEPTH        = crf_pkg::DEPTH_DEF,
   parameter int ELEMENT_BITS = crf_pkg::ELEMENT_BITS_DEF,
   parameter int MAX_BURST    = crf_pkg::MAX_BURST_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [crf_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [ELEMENT_BITS-1:0]          req_value,
   input  wire logic [crf_pkg::COUNT_W-1:0]      req_count,
   output crf_pkg::crf_stage_type                stage,
   input  wire logic                             stage_take,
   output logic                                  wr_en,
   output logic [$clog2(DEPTH)-1:0]              wr_addr,
   output logic [ELEMENT_BITS-1:0]               wr_data,
   output logic                                  rd_en,
   output logic [$clog2(DEPTH)-1:0]              rd_addr
);

   import crf_pkg::*;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int BURST_W = $clog2(MAX_BURST + 1);
   localparam int SUM_W   = CNT_W + BURST_W;

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_BURST = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    rp_ff, rp_in, wp_ff, wp_in, rp_next, wp_next;
   logic [CNT_W-1:0]    held_ff, held_in, held_inc, held_dec;
   logic                open_ff, open_in;
   logic [BURST_W-1:0]  left_ff, left_in, cnt;
   logic                tail_ff, tail_in;
   logic                s1_valid_ff, s1_valid_in;
   crf_meta_type        s1_meta_ff, s1_meta_in;
   logic                load_ok, accept;
   logic [SUM_W-1:0]    room_sum;

   assign rp_next  = (rp_ff == PTR_W'(DEPTH - 1)) ? '0 : rp_ff + 1'b1;
   assign wp_next  = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign held_inc = held_ff + 1'b1;
   assign held_dec = held_ff - 1'b1;

   // count saturated into 1..MAX_BURST
   always_comb begin
      priority if (req_count == '0) begin
         cnt = BURST_W'(1);
      end else if (req_count > COUNT_W'(MAX_BURST)) begin
         cnt = BURST_W'(MAX_BURST);
      end else begin
         cnt = BURST_W'(req_count);
      end
   end

   assign room_sum  = SUM_W'(held_ff) + SUM_W'(cnt);
   assign load_ok   = !s1_valid_ff || stage_take;
   assign req_ready = (state_ff == S_IDLE) && load_ok;
   assign accept    = req_valid && req_ready;

   assign wr_addr = wp_ff;
   assign wr_data = req_value;
   assign rd_addr = rp_ff;

   always_comb begin
      state_in    = state_ff;
      rp_in       = rp_ff;
      wp_in       = wp_ff;
      held_in     = held_ff;
      open_in     = open_ff;
      left_in     = left_ff;
      tail_in     = tail_ff;
      s1_valid_in = s1_valid_ff && !stage_take;
      s1_meta_in  = s1_meta_ff;
      wr_en       = 1'b0;
      rd_en       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               s1_valid_in           = 1'b1;
               s1_meta_in.status     = ST_OK;
               s1_meta_in.data_valid = 1'b0;
               s1_meta_in.last       = 1'b1;
               s1_meta_in.fill_level = FILL_W'(held_ff);
               unique case (req_cmd)
                  CMD_PUSH: begin
                     priority if (!open_ff) begin
                        s1_meta_in.status = ST_CLOSED;
                     end else if (held_ff == CNT_W'(DEPTH)) begin
                        s1_meta_in.status = ST_WAIT;
                     end else begin
                        wr_en                 = 1'b1;
                        wp_in                 = wp_next;
                        held_in               = held_inc;
                        s1_meta_in.fill_level = FILL_W'(held_inc);
                     end
                  end
                  CMD_PUSH_N: begin
                     priority if (!open_ff) begin
                        s1_meta_in.status = ST_CLOSED;
                     end else if (room_sum > SUM_W'(DEPTH)) begin
                        s1_meta_in.status = ST_WAIT;
                     end else begin
                        s1_meta_in.status = ST_OK;
                     end
                  end
                  CMD_PULL: begin
                     if (held_ff == '0) begin
                        s1_meta_in.status = open_ff ? ST_WAIT : ST_CLOSED;
                     end else begin
                        rd_en                 = 1'b1;
                        rp_in                 = rp_next;
                        held_in               = held_dec;
                        s1_meta_in.data_valid = 1'b1;
                        s1_meta_in.fill_level = FILL_W'(held_dec);
                     end
                  end
                  CMD_PULL_N: begin
                     priority if (SUM_W'(held_ff) >= SUM_W'(cnt)) begin
                        // full run, first element now
                        rd_en                 = 1'b1;
                        rp_in                 = rp_next;
                        held_in               = held_dec;
                        s1_meta_in.data_valid = 1'b1;
                        s1_meta_in.last       = (cnt == BURST_W'(1));
                        s1_meta_in.fill_level = FILL_W'(held_dec);
                        left_in               = cnt - 1'b1;
                        tail_in               = 1'b0;
                        if (cnt != BURST_W'(1)) begin
                           state_in = S_BURST;
                        end
                     end else if (open_ff) begin
                        s1_meta_in.status = ST_WAIT;
                     end else if (held_ff == '0) begin
                        s1_meta_in.status = ST_CLOSED;
                     end else begin
                        // closed and short: drain, then a closed marker
                        rd_en                 = 1'b1;
                        rp_in                 = rp_next;
                        held_in               = held_dec;
                        s1_meta_in.data_valid = 1'b1;
                        s1_meta_in.last       = 1'b0;
                        s1_meta_in.fill_level = FILL_W'(held_dec);
                        left_in               = BURST_W'(held_dec);
                        tail_in               = 1'b1;
                        state_in              = S_BURST;
                     end
                  end
                  CMD_CLOSE: begin
                     open_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_BURST: begin
            if (load_ok) begin
               s1_valid_in = 1'b1;
               if (left_ff != '0) begin
                  rd_en                 = 1'b1;
                  rp_in                 = rp_next;
                  held_in               = held_dec;
                  left_in               = left_ff - 1'b1;
                  s1_meta_in.status     = ST_OK;
                  s1_meta_in.data_valid = 1'b1;
                  s1_meta_in.last       = (left_ff == BURST_W'(1)) && !tail_ff;
                  s1_meta_in.fill_level = FILL_W'(held_dec);
                  if ((left_ff == BURST_W'(1)) && !tail_ff) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  s1_meta_in.status     = ST_CLOSED;
                  s1_meta_in.data_valid = 1'b0;
                  s1_meta_in.last       = 1'b1;
                  s1_meta_in.fill_level = FILL_W'(held_ff);
                  tail_in               = 1'b0;
                  state_in              = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rp_ff       <= '0;
         wp_ff       <= '0;
         held_ff     <= '0;
         open_ff     <= 1'b1;
         left_ff     <= '0;
         tail_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rp_ff       <= rp_in;
         wp_ff       <= wp_in;
         held_ff     <= held_in;
         open_ff     <= open_in;
         left_ff     <= left_in;
         tail_ff     <= tail_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff <= s1_meta_in;
   end

   assign stage.valid = s1_valid_ff;
   assign stage.meta  = s1_meta_ff;

endmodule : crf_seq

`default_nettype wire

@@ hw/rtl/closable_ring_fifo_unit.sv @@
// path: a response passes the sequencer result stage, then the output register
// throughput: one single-response request per cycle while responses are taken; pull_n
//   runs stream one element per cycle out of the store unless stalled, next request taken once the run is issued
// reset: synchronous, clears pointers and fill count and reopens the queue;
//   the element store is not cleared and needs no sweep
`timescale 1ns / 1ps
`default_nettype none

// top level: command sequencer, element store and response register
// depends on crf_pkg, crf_ram and crf_seq

module closable_ring_fifo_unit #(
   parameter int DEPTH        = crf_pkg::DEPTH_DEF,
   parameter int ELEMENT_BITS = crf_pkg::ELEMENT_BITS_DEF,
   parameter int MAX_BURST    = crf_pkg::MAX_BURST_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request side
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [crf_pkg::REQ_TDATA_W-1:0]    req_tdata,  // data[63:0], count[70:64], pad
   input  wire logic [crf_pkg::CMD_W-1:0]          req_tuser,  // cmd[2:0]
   // response side
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [crf_pkg::RSP_TDATA_W-1:0]         rsp_tdata,  // data_res[63:0], fill_level[74:64], pad
   output logic [crf_pkg::RSP_TUSER_W-1:0]         rsp_tuser,  // status[1:0], data_valid[2]
   output logic                                    rsp_tlast
);

   import crf_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   // sequencer to store
   logic                    wr_en, rd_en;
   logic [ADDR_W-1:0]       wr_addr, rd_addr;
   logic [ELEMENT_BITS-1:0] wr_data, rd_data;

   // result stage and response register
   crf_stage_type           stage;
   logic                    stage_take;
   logic                    out_valid_ff, out_valid_in;
   crf_meta_type            out_meta_ff;
   logic [DATA_W-1:0]       out_data_ff;

   crf_seq #(
      .DEPTH        (DEPTH),
      .ELEMENT_BITS (ELEMENT_BITS),
      .MAX_BURST    (MAX_BURST)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser),
      .req_value  (req_tdata[ELEMENT_BITS-1:0]),
      .req_count  (req_tdata[DATA_W +: COUNT_W]),
      .stage      (stage),
      .stage_take (stage_take),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   // element store; the read register holds its word until the next read
   crf_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stage moves on when the response register is empty or being drained
   assign stage_take   = stage.valid && (!out_valid_ff || rsp_tready);
   assign out_valid_in = stage_take || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset; element is zero where no element was taken
   always_ff @(posedge clock) begin
      if (stage_take) begin
         out_meta_ff <= stage.meta;
         out_data_ff <= stage.meta.data_valid ? DATA_W'(rd_data) : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - DATA_W - FILL_W){1'b0}},
                        out_meta_ff.fill_level, out_data_ff};
   assign rsp_tuser  = {out_meta_ff.data_valid, out_meta_ff.status};
   assign rsp_tlast  = out_meta_ff.last;

endmodule : closable_ring_fifo_unit

`default_nettype wire

@@ hw/rtl/crf_checker.sv @@
// port-level checks for closable_ring_fifo_unit, attached by bind
// depends on crf_pkg
`timescale 1ns / 1ps
`default_nettype none

module crf_checker #(
   parameter int DEPTH = crf_pkg::DEPTH_DEF
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [crf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [crf_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   input wire logic                            rsp_tlast
);

   import crf_pkg::*;

   // a returned element always comes with an ok status
   a_valid_is_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == ST_OK)
      else $error("element returned with non-ok status");

   // wait and closed answers end their request
   a_refusal_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] != ST_OK) |-> rsp_tlast)
      else $error("refusal without last");

   // fill level never exceeds the store
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[DATA_W +: FILL_W] <= FILL_W'(DEPTH))
      else $error("fill level above depth");

   // consecutive elements of a run drop the fill level by one
   a_run_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tuser[2] && !rsp_tlast
      ##1 rsp_tvalid && rsp_tuser[2]
      |-> rsp_tdata[DATA_W +: FILL_W] == $past(rsp_tdata[DATA_W +: FILL_W]) - 1'b1)
      else $error("run fill level out of step");

   // stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
      && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled response changed");

endmodule : crf_checker

bind closable_ring_fifo_unit crf_checker #(
   .DEPTH (DEPTH)
) u_crf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
